>>> hdl/rprop_pkg.sv
// shared types, widths and constants of the rprop weight update engine
package rprop_pkg;

   localparam int ENTRIES   = 4096;
   localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_W     = 12;
   localparam int WEIGHT_W  = 24;
   localparam int STEP_W    = 23;
   localparam int INC_W     = 17;
   localparam int DEC_W     = 16;
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = STEP_W + INC_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 23;

   localparam logic [STEP_W-1:0] STEP_MAX         = {STEP_W{1'b1}};
   localparam logic [INC_W-1:0]  INC_RESET        = 17'd78643;
   localparam logic [DEC_W-1:0]  DEC_RESET        = 16'd32768;
   localparam logic [STEP_W-1:0] INIT_STEP_RESET  = 23'd6554;
   localparam logic [PROD_W-1:0] ROUND_HALF       = PROD_W'(32768);

   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   typedef enum logic {
      REQ_UPDATE  = 1'b0,
      REQ_RESTART = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INCREASE  = 2'd0,
      CSR_DECREASE  = 2'd1,
      CSR_INIT_STEP = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      sign_type          sign;
   } entry_type;

endpackage

>>> hdl/rprop_ifs.sv
// valid/ready channel interfaces: update requests, results and register writes
interface rprop_req_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       req_type;
   logic        [rprop_pkg::IDX_W-1:0]         param_index;
   logic signed [rprop_pkg::WEIGHT_W-1:0]      weight_in;
   logic signed [rprop_pkg::WEIGHT_W-1:0]      grad_in;

   modport source (output valid, req_type, param_index, weight_in, grad_in, input ready);
   modport sink   (input valid, req_type, param_index, weight_in, grad_in, output ready);
endinterface

interface rprop_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic        [rprop_pkg::IDX_W-1:0]         index_out;
   logic signed [rprop_pkg::WEIGHT_W-1:0]      weight_out;
   logic        [rprop_pkg::STEP_W-1:0]        step_out;
   logic                                       moved;

   modport source (output valid, index_out, weight_out, step_out, moved, input ready);
   modport sink   (input valid, index_out, weight_out, step_out, moved, output ready);
endinterface

interface rprop_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rprop_pkg::CSR_IDX_W-1:0]     index;
   logic [rprop_pkg::CSR_DAT_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/rprop_weight_update_engine_top.sv
// Rprop weight update engine: per-parameter step and sign table in one
// simple dual-port synchronous memory, updated by read, multiply and write back.
// When results are taken as they come, update items overlap: the table read
// is registered at the accepting edge, the step is scaled in the multiply
// state and written back in the writeback state once the result register is
// free, and in that state the next item is already accepted and its read
// forwarded from the write when both hit the same entry. The result is
// registered with the write-back. A restart item, and reset, start a clearing
// pass over all ENTRIES (4096) entries that loads the initial step into every
// entry; no item is accepted during that pass, register writes are. An update
// with an index beyond the table gives no result.
module rprop_weight_update_engine_top (
   input  logic             clock,
   input  logic             reset,
   rprop_req_if.sink        req,
   rprop_rsp_if.source      rsp,
   rprop_csr_if.sink        csr
);
   import rprop_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_WB,
      ST_SWEEP
   } state_type;

   // table storage
   entry_type mem [ENTRIES];

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        sweep_addr_ff, sweep_addr_in;
   logic [STEP_W-1:0]        fill_step_ff, fill_step_in;
   logic [INC_W-1:0]         inc_ff, inc_in;
   logic [DEC_W-1:0]         dec_ff, dec_in;
   logic [STEP_W-1:0]        init_ff, init_in;

   logic [IDX_W-1:0]         cur_index_ff, cur_index_in;
   logic [WEIGHT_W-1:0]      cur_weight_ff, cur_weight_in;
   logic [WEIGHT_W-1:0]      cur_grad_ff, cur_grad_in;
   logic                     fwd_ff, fwd_in;
   entry_type                fwd_data_ff, fwd_data_in;
   logic [STEP_W-1:0]        old_step_ff, old_step_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [WEIGHT_W-1:0]      rsp_weight_ff, rsp_weight_in;
   logic [STEP_W-1:0]        rsp_step_ff, rsp_step_in;
   logic                     rsp_moved_ff, rsp_moved_in;

   entry_type                rd_data_ff;

   logic                     out_free;
   logic                     req_ready;
   logic                     req_acc;
   logic                     idx_ok;
   logic                     wb_go;
   entry_type                entry_cur;
   sign_type                 grad_sign;
   logic                     opposite;
   logic [INC_W-1:0]         factor;
   logic                     grad_zero;
   logic                     grad_neg;
   logic [WEIGHT_W-1:0]      scaled;
   logic [STEP_W-1:0]        sat_step;
   logic [STEP_W-1:0]        new_step;
   logic [WEIGHT_W:0]        w_ext;
   logic [WEIGHT_W:0]        s_ext;
   logic [WEIGHT_W:0]        w_sum;
   logic [WEIGHT_W-1:0]      new_weight;
   entry_type                wb_data;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   entry_type                mem_wdata;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_WB) && out_free);
   assign req_acc   = req.valid && req_ready;
   assign idx_ok    = 32'(req.param_index) < 32'(ENTRIES);
   assign wb_go     = (state_ff == ST_WB) && out_free;

   assign req.ready      = req_ready;
   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.index_out  = rsp_index_ff;
   assign rsp.weight_out = rsp_weight_ff;
   assign rsp.step_out   = rsp_step_ff;
   assign rsp.moved      = rsp_moved_ff;

   // multiply stage: pick factor from sign history
   always_comb begin
      entry_cur = fwd_ff ? fwd_data_ff : rd_data_ff;
      grad_sign = cur_grad_ff[WEIGHT_W-1] ? SIGN_NEG : SIGN_POS;
      opposite  = (entry_cur.sign != SIGN_NONE) && (entry_cur.sign != grad_sign);
      factor    = opposite ? INC_W'(dec_ff) : inc_ff;
   end

   // writeback stage: drop fraction bits, saturate, move weight
   always_comb begin
      grad_zero = (cur_grad_ff == '0);
      grad_neg  = cur_grad_ff[WEIGHT_W-1];
      scaled    = prod_ff[PROD_W-1:FRAC_W];
      sat_step  = scaled[WEIGHT_W-1] ? STEP_MAX : scaled[STEP_W-1:0];
      new_step  = grad_zero ? old_step_ff : sat_step;
      w_ext     = {cur_weight_ff[WEIGHT_W-1], cur_weight_ff};
      s_ext     = (WEIGHT_W+1)'(new_step);
      w_sum     = grad_neg ? (w_ext + s_ext) : (w_ext - s_ext);
      if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
         new_weight = w_sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                      : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else begin
         new_weight = w_sum[WEIGHT_W-1:0];
      end
      if (grad_zero) begin
         new_weight = cur_weight_ff;
      end
      wb_data.step = new_step;
      wb_data.sign = grad_zero ? SIGN_NONE : (grad_neg ? SIGN_NEG : SIGN_POS);
   end

   always_comb begin
      mem_we    = (state_ff == ST_SWEEP) || wb_go;
      mem_waddr = (state_ff == ST_SWEEP) ? sweep_addr_ff : ADDR_W'(cur_index_ff);
      if (state_ff == ST_SWEEP) begin
         mem_wdata.step = fill_step_ff;
         mem_wdata.sign = SIGN_NONE;
      end else begin
         mem_wdata = wb_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[ADDR_W'(req.param_index)];
   end

   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      fill_step_in  = fill_step_ff;
      inc_in        = inc_ff;
      dec_in        = dec_ff;
      init_in       = init_ff;
      cur_index_in  = cur_index_ff;
      cur_weight_in = cur_weight_ff;
      cur_grad_in   = cur_grad_ff;
      fwd_in        = fwd_ff;
      fwd_data_in   = fwd_data_ff;
      old_step_in   = old_step_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_step_in   = rsp_step_ff;
      rsp_moved_in  = rsp_moved_ff;

      if (csr.valid) begin
         unique case (csr.index)
            CSR_INCREASE:  inc_in  = csr.data[INC_W-1:0];
            CSR_DECREASE:  dec_in  = csr.data[DEC_W-1:0];
            CSR_INIT_STEP: init_in = csr.data[STEP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: ;
         ST_MUL: begin
            old_step_in = entry_cur.step;
            prod_in     = PROD_W'(entry_cur.step) * PROD_W'(factor) + ROUND_HALF;
            state_in    = ST_WB;
         end
         ST_WB: begin
            if (wb_go) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = cur_index_ff;
               rsp_weight_in = new_weight;
               rsp_step_in   = new_step;
               rsp_moved_in  = !grad_zero;
               state_in      = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            sweep_addr_in = sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == ADDR_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (req_acc) begin
         cur_index_in  = req.param_index;
         cur_weight_in = req.weight_in;
         cur_grad_in   = req.grad_in;
         // the entry being written this cycle is read stale, forward it
         fwd_in        = wb_go && (ADDR_W'(req.param_index) == ADDR_W'(cur_index_ff));
         fwd_data_in   = wb_data;
         if (req.req_type == REQ_RESTART) begin
            fill_step_in  = init_ff;
            sweep_addr_in = '0;
            state_in      = ST_SWEEP;
         end else if (idx_ok) begin
            state_in = ST_MUL;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         fill_step_ff  <= INIT_STEP_RESET;
         inc_ff        <= INC_RESET;
         dec_ff        <= DEC_RESET;
         init_ff       <= INIT_STEP_RESET;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         fill_step_ff  <= fill_step_in;
         inc_ff        <= inc_in;
         dec_ff        <= dec_in;
         init_ff       <= init_in;
         fwd_ff        <= fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_index_ff  <= cur_index_in;
      cur_weight_ff <= cur_weight_in;
      cur_grad_ff   <= cur_grad_in;
      fwd_data_ff   <= fwd_data_in;
      old_step_ff   <= old_step_in;
      prod_ff       <= prod_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_moved_ff  <= rsp_moved_in;
   end

endmodule
